[rtl/rbf_neuron_kernel_defines.svh]
// Assertion macros for the radial-basis neuron.
`ifndef RBF_NEURON_KERNEL_DEFINES_SVH
`define RBF_NEURON_KERNEL_DEFINES_SVH
`ifndef SYNTHESIS
`define RBF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rbf assertion failed");
`define RBF_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("rbf forbidden condition seen");
`else
`define RBF_ASSERT(lbl, clk, rstn, prop)
`define RBF_NEVER(lbl, clk, rstn, prop)
`endif
`endif

[rtl/rbf_pkg.sv]
`timescale 1ns / 1ps
package rbf_pkg;

    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int MAG_W = 22;
    localparam int DIV_STEPS = MAG_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int SUM_W = 40;
    localparam int INV_W = 17;
    localparam int MEAN_W = 41;
    localparam int P_W = 31;
    localparam logic [INV_W-1:0] INV_RESET = 17'd1024;
    localparam logic [P_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             wzero;
        logic [15:0]      w;
        logic             last;
    } t_item;

    function automatic logic [29:0] f_pow_half(input logic [3:0] k);
        logic [29:0] v;
        unique case (k)
            4'd0:    v = 30'd759250125;
            4'd1:    v = 30'd902905651;
            4'd2:    v = 30'd984625594;
            4'd3:    v = 30'd1028218693;
            4'd4:    v = 30'd1050733747;
            4'd5:    v = 30'd1062175491;
            4'd6:    v = 30'd1067942999;
            4'd7:    v = 30'd1070838486;
            4'd8:    v = 30'd1072289173;
            4'd9:    v = 30'd1073015252;
            4'd10:   v = 30'd1073378477;
            4'd11:   v = 30'd1073560135;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rbf_front.sv]
`timescale 1ns / 1ps
module rbf_front (
    input  logic signed [15:0] i_feature_value,
    input  logic signed [15:0] i_center_value,
    input  logic [15:0]        i_width_value,
    input  logic               i_last_input,
    output rbf_pkg::t_item     o_item
);
    import rbf_pkg::*;

    logic signed [16:0] w_diff;
    logic [16:0]        w_abs;

    assign w_diff = 17'(i_feature_value) - 17'(i_center_value);
    assign w_abs = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);

    always_comb begin
        o_item.mag = {w_abs, 5'b0};
        o_item.neg = w_diff[16];
        o_item.wzero = (i_width_value == 16'd0);
        o_item.w = i_width_value;
        o_item.last = i_last_input;
    end
endmodule

[rtl/rbf_queue.sv]
`timescale 1ns / 1ps
module rbf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rbf_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output rbf_pkg::t_item o_item
);
    import rbf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_item           r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;

    assign o_full = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

[rtl/rbf_back.sv]
`timescale 1ns / 1ps
`include "rbf_neuron_kernel_defines.svh"
module rbf_back #(
    parameter int EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  rbf_pkg::t_item            i_item,
    output logic                      o_pop,
    input  logic [rbf_pkg::INV_W-1:0] i_inverse_count,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [16:0]               o_activation,
    output logic                      o_overflowed
);
    import rbf_pkg::*;

    localparam int KW = $clog2(EXP_TABLE_BITS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_ACC  = 8'b0000_1000,
        S_MULA = 8'b0001_0000,
        S_MULB = 8'b0010_0000,
        S_EXP  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_item              r_item;
    logic [MAG_W-1:0]   r_dvd;
    logic [15:0]        r_rem;
    logic [4:0]         r_cnt;
    logic [31:0]        r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic               r_sat;
    logic               r_flag;
    logic [36:0]        r_pp;
    logic [MEAN_W-1:0]  r_mean;
    logic [P_W-1:0]     r_p;
    logic [KW-1:0]      r_k;
    logic               r_out_valid;
    logic [16:0]        r_act;
    logic               r_ovf;

    logic [16:0]        w_trial;
    logic               w_ge;
    logic [15:0]        w_m;
    logic               w_qsat;
    logic [SUM_W:0]     w_add;
    logic [36:0]        w_hi;
    logic [56:0]        w_total;
    logic [3:0]         w_idx;
    logic [60:0]        w_prod;
    logic [4:0]         w_sh;
    logic [31:0]        w_rnd;
    logic               w_big;
    logic               w_out_free;

    assign w_trial = {r_rem, r_dvd[MAG_W-1]};
    assign w_ge = (w_trial >= {1'b0, r_item.w});

    always_comb begin
        w_m = r_dvd[15:0];
        w_qsat = 1'b0;
        if (r_item.wzero) begin
            w_m = 16'd32767;
            w_qsat = 1'b1;
        end else if (r_item.neg) begin
            if (r_dvd > MAG_W'(32768)) begin
                w_m = 16'd32768;
                w_qsat = 1'b1;
            end
        end else if (r_dvd > MAG_W'(32767)) begin
            w_m = 16'd32767;
            w_qsat = 1'b1;
        end
    end

    assign w_add = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    assign w_hi = r_sum[39:20] * i_inverse_count;
    assign w_total = 57'(r_pp) + {w_hi, 20'b0};
    assign w_idx = 4'(r_k);
    assign w_prod = r_p * f_pow_half(w_idx);
    assign w_big = (r_mean[MEAN_W-1:16] >= 25'd17);
    assign w_sh = r_mean[20:16];
    assign w_rnd = ({1'b0, r_p} + (32'd1 << (5'd13 + w_sh))) >> (5'd14 + w_sh);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_activation = r_act;
    assign o_overflowed = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum <= '0;
            r_sat <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt <= '0;
            r_k <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item <= i_item;
                        r_dvd <= i_item.mag;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 16'(w_trial - {1'b0, r_item.w}) : w_trial[15:0];
                    r_dvd <= {r_dvd[MAG_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq <= w_m * w_m;
                    if (w_qsat) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_add[SUM_W]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= w_add[SUM_W-1:0];
                    end
                    r_state <= r_item.last ? S_MULA : S_IDLE;
                end
                S_MULA: begin
                    r_pp <= r_sum[19:0] * i_inverse_count;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_mean <= w_total[56:16];
                    r_flag <= r_sat;
                    r_sum <= '0;
                    r_sat <= 1'b0;
                    r_p <= ONE_Q30;
                    r_k <= '0;
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    if (r_mean[4'd15 - w_idx]) begin
                        r_p <= P_W'((w_prod + 61'(ONE_Q30 >> 1)) >> 30);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(EXP_TABLE_BITS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_act <= w_big ? 17'd0 : w_rnd[16:0];
                        r_ovf <= r_flag;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RBF_ASSERT(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN))
    `RBF_ASSERT(a_sum_cleared, i_clk, i_rst_n, (r_state == S_MULB) |=> (r_sum == '0 && !r_sat))
    `RBF_ASSERT(a_div_count, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt < 5'(DIV_STEPS)))
    `RBF_NEVER(a_pop_busy, i_clk, i_rst_n, o_pop && (r_state != S_IDLE))
endmodule

[rtl/rbf_neuron_kernel.sv]
// The back end takes one word at a time: the 22-step shared divider, then S_SQ and S_ACC.
// A word marked last then passes S_MULA and S_MULB for the mean, S_EXP for the exponent and S_FIN.
// The result is registered in S_FIN, which waits there while the output is stalled.
// A two-word queue lets the front accept while the back end is busy.
// Reset is synchronous, active low, and clears the sum, the flag and inverse_count to 1024.
`timescale 1ns / 1ps
module rbf_neuron_kernel #(
    parameter int EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_feature_value,
    input  logic signed [15:0] i_center_value,
    input  logic [15:0]        i_width_value,
    input  logic               i_last_input,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [16:0]        o_activation,
    output logic               o_overflowed,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rbf_pkg::*;

    localparam logic [2:0] ADDR_INV = 3'd0;

    logic [INV_W-1:0] r_inv;
    t_item            w_front_item;
    t_item            w_q_item;
    logic             w_full, w_empty, w_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_INV) ? {15'b0, r_inv} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_INV) begin
            r_inv <= pwdata[INV_W-1:0];
        end
    end

    assign o_in_stall = w_full;

    rbf_front u_front (
        .i_feature_value (i_feature_value),
        .i_center_value  (i_center_value),
        .i_width_value   (i_width_value),
        .i_last_input    (i_last_input),
        .o_item          (w_front_item)
    );

    rbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !w_full),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    rbf_back #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .i_inverse_count (r_inv),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_activation    (o_activation),
        .o_overflowed    (o_overflowed)
    );
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int EXP_BITS = rbf_pkg::EXP_TABLE_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [2:0] ADDR_INVERSE_COUNT = 3'd0;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] c;
        logic [15:0]        w;
        logic               last;
    } t_word;

    typedef struct {
        logic [16:0] act;
        logic        ovf;
    } t_activation;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [15:0] i_feature_value = '0;
    logic signed [15:0] i_center_value = '0;
    logic [15:0] i_width_value = '0;
    logic i_last_input = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [16:0] o_activation;
    logic o_overflowed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rbf_neuron_kernel i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_word pending_words[$];
    t_activation expected_activations[$];
    logic [39:0] model_sum;
    logic model_sat;
    logic [16:0] model_inv;
    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit hold_sender = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [16:0] pow2_neg(input logic [40:0] mean);
        logic [24:0] ip;
        logic [15:0] f;
        logic [63:0] p;
        logic [29:0] tab[12];
        tab = '{30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
                30'd1050733747, 30'd1062175491, 30'd1067942999, 30'd1070838486,
                30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135};
        ip = mean[40:16];
        f = mean[15:0];
        p = 64'd1 << 30;
        if (ip >= 17) return '0;
        for (int k = 0; k < EXP_BITS && k < 12; k++) begin
            if (f[15-k]) begin
                p = (p * tab[k] + (64'd1 << 29)) >> 30;
            end
        end
        return 17'((p + (64'd1 << (13 + ip))) >> (14 + ip));
    endfunction

    task automatic predict_word(input t_word wd);
        int diff;
        logic [31:0] mag;
        logic [31:0] q;
        logic [63:0] sq;
        logic [63:0] prod;
        t_activation r;
        diff = int'(wd.x) - int'(wd.c);
        mag = (diff < 0 ? -diff : diff) * 32;
        if (wd.w == 0) begin
            model_sat = 1'b1;
            q = 32767;
        end else begin
            q = mag / wd.w;
            if (diff < 0 && q > 32768) begin
                model_sat = 1'b1;
                q = 32768;
            end else if (diff >= 0 && q > 32767) begin
                model_sat = 1'b1;
                q = 32767;
            end
        end
        sq = q * q;
        if (sq > (64'hFF_FFFF_FFFF - model_sum)) begin
            model_sum = '1;
            model_sat = 1'b1;
        end else begin
            model_sum = model_sum + sq[39:0];
        end
        if (wd.last) begin
            prod = model_sum * model_inv;
            r.act = pow2_neg(41'(prod >> 16));
            r.ovf = model_sat;
            expected_activations.push_back(r);
            model_sum = '0;
            model_sat = 1'b0;
        end
    endtask

    // The driver pushes words and predicts each one at acceptance.
    always @(posedge i_clk) begin
        t_word wd;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_word('{i_feature_value, i_center_value, i_width_value, i_last_input});
                words_sent <= words_sent + 1;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0 || hold_sender || pending_words.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    wd = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_feature_value <= wd.x;
                    i_center_value <= wd.c;
                    i_width_value <= wd.w;
                    i_last_input <= wd.last;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_activation e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_activations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected word: activation %0d overflowed %0b",
                                 o_activation, o_overflowed);
                end else begin
                    e = expected_activations.pop_front();
                    if (e.act !== o_activation || e.ovf !== o_overflowed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d/%0b, got %0d/%0b",
                                     e.act, e.ovf, o_activation, o_overflowed);
                    end
                end
            end
            if (recv_gap > 0) begin
                i_out_stall <= 1'b1;
                recv_gap <= recv_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", expected_activations.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_inverse_count(input logic [16:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_INVERSE_COUNT;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_inv = value;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !i_in_valid);
        hold_sender = 1'b1;
        wait (expected_activations.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_word rand_word(input int mode, input logic last);
        t_word wd;
        wd.x = 16'($urandom);
        wd.c = 16'($urandom);
        case (mode)
            0: wd.w = 16'($urandom);
            1: wd.w = 16'($urandom_range(4096, 65535));
            2: wd.w = 16'($urandom_range(0, 15));
            default: wd.w = 16'($urandom_range(1024, 20000));
        endcase
        if (mode == 3) wd.c = wd.x + 16'(int'($urandom_range(0, 4000)) - 2000);
        wd.last = last;
        return wd;
    endfunction

    task automatic queue_neuron(input int len);
        int mode;
        mode = $urandom_range(0, 9) < 2 ? $urandom_range(0, 2) : 3;
        for (int i = 0; i < len; i++)
            pending_words.push_back(rand_word(mode, i == len - 1));
    endtask

    initial begin
        logic [16:0] inv_settings[5];
        inv_settings = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd16384};
        model_sum = '0;
        model_sat = 1'b0;
        model_inv = rbf_pkg::INV_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, zero width, saturation and the reset count.
        pending_words.push_back('{16'sh7FFF, 16'sh8000, 16'd1, 1'b0});
        pending_words.push_back('{16'sh8000, 16'sh7FFF, 16'd1, 1'b1});
        pending_words.push_back('{16'sh0000, 16'sh0000, 16'd0, 1'b1});
        pending_words.push_back('{16'sh1234, 16'sh1234, 16'hFFFF, 1'b1});
        pending_words.push_back('{16'sh0100, 16'sh0000, 16'd4096, 1'b1});
        pending_words.push_back('{16'sh8000, 16'sh0000, 16'd32, 1'b1});
        pending_words.push_back('{16'sh7FFF, 16'sh0000, 16'd32, 1'b1});
        pending_words.push_back('{16'shFFFF, 16'sh0000, 16'd2, 1'b1});
        for (int i = 0; i < 40; i++)
            pending_words.push_back('{16'sh7FFF, 16'sh8000, 16'd1, i == 39});
        hold_sender = 1'b0;
        drain();

        for (int s = 0; s < 5; s++) begin
            write_inverse_count(inv_settings[s]);
            hold_sender = 1'b0;
            pending_words.push_back('{16'sh4000, 16'shC000, 16'd8192, 1'b1});
            for (int n = 0; n < 18; n++)
                queue_neuron($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8));
            drain();
        end
        write_inverse_count(17'd1024);
        hold_sender = 1'b0;
        for (int n = 0; n < 6; n++) queue_neuron($urandom_range(1, 6));
        drain();

        $display("Sent %0d words over six inverse count settings, checked %0d activations.",
                 words_sent, results_seen);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rbf_pkg.sv
rtl/rbf_front.sv
rtl/rbf_queue.sv
rtl/rbf_back.sv
rtl/rbf_neuron_kernel.sv
verif/tb_top.sv
